>>> hdl/ped_pkg.sv
// Shared types and constants of the peak extremum decimator.
// No dependencies; used by the top level and by the stream interface users.
package ped_pkg;

  localparam int unsigned ChanW    = 6;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned BinSizeW = 13;
  localparam int unsigned LimitW   = 7;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [1:0] {
    KIND_NEURAL  = 2'd0,
    KIND_ANALOG  = 2'd1,
    KIND_DIGITAL = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIN_SIZE     = 2'd0,
    CFG_NEURAL_LIMIT = 2'd1,
    CFG_ANALOG_LIMIT = 2'd2,
    CFG_SHOWN_MASK   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ChanW-1:0]          channel;
    logic signed [SampleW-1:0] sample;
    logic                      block_end;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]          out_channel;
    logic signed [SampleW-1:0] point;
    kind_e                     kind;
  } out_item_t;

endpackage

>>> hdl/ped_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; the decimator uses ped_pkg item structs.
interface ped_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/peak_extremum_decimator.sv
// Peak extremum decimator: per-channel min/max binning of interleaved samples.
// Uses ped_pkg (types, codes) and ped_stream_if (input and output channels).
//
// Usage:
//   in_i  carries one sample per transfer: channel, signed sample, block_end.
//   out_o carries decimated points: out_channel, point, kind. Each input
//   transfer yields zero or one output transfer, in input order.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   the block is idle: bin size, neural and analog channel limits, shown mask.
// Throughput: one sample per cycle while no point is blocked. Per-channel state
//   sits in one synchronous memory read at acceptance and written back from the
//   compare stage; a back-to-back sample of the same channel takes the written
//   word over a forwarding path, so no bubble is needed.
// Path: an accepted sample loads the stage 1 registers, and a point that it emits
//   is loaded from there into the output register that drives out_o.
// Receiver stall: the output register holds its point; the compare stage
//   keeps working while its sample emits nothing, and input ready drops only
//   when a second point would have to wait behind the held one.
// Reset: configuration returns to bin size 1, all channels digital, all shown;
//   every bin position reads as zero at once through per-channel valid bits.
//   Running extrema are undefined until the first sample of a bin writes them.
module peak_extremum_decimator #(
  parameter int unsigned MAX_CHANNELS = 64,
  parameter int unsigned MAX_BIN      = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ped_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ped_pkg::CfgW-1:0]      cfg_wdata_i,
  ped_stream_if.sink                    in_i,
  ped_stream_if.source                  out_o
);

  localparam int unsigned IdxW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned PosW  = (MAX_BIN > 1) ? $clog2(MAX_BIN) : 1;
  localparam int unsigned SW    = ped_pkg::SampleW;
  localparam int unsigned WordW = PosW + 2 * SW;
  localparam int unsigned BsW   = ped_pkg::BinSizeW;
  localparam int unsigned LimW  = ped_pkg::LimitW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BsW-1:0]  bin_size_q;
  logic [LimW-1:0] neural_limit_q;
  logic [LimW-1:0] analog_limit_q;
  logic [63:0]     shown_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_size_q     <= BsW'(1);
      neural_limit_q <= '0;
      analog_limit_q <= '0;
      shown_mask_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ped_pkg::CFG_BIN_SIZE:     bin_size_q     <= cfg_wdata_i[BsW-1:0];
        ped_pkg::CFG_NEURAL_LIMIT: neural_limit_q <= cfg_wdata_i[LimW-1:0];
        ped_pkg::CFG_ANALOG_LIMIT: analog_limit_q <= cfg_wdata_i[LimW-1:0];
        ped_pkg::CFG_SHOWN_MASK:   shown_mask_q   <= cfg_wdata_i[63:0];
        default: ;
      endcase
    end
  end

  // Clamp the bin size: zero acts as one, large values saturate.
  logic [BsW-1:0] size_eff;
  always_comb begin
    if (bin_size_q == '0) begin
      size_eff = BsW'(1);
    end else if (bin_size_q > BsW'(MAX_BIN)) begin
      size_eff = BsW'(MAX_BIN);
    end else begin
      size_eff = bin_size_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: accept a sample and read its channel's state word
  // ---------------------------------------------------------------------------
  logic            in_ready;
  logic            in_fire;
  logic [IdxW-1:0] rd_idx;

  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  assign rd_idx     = in_i.data.channel[IdxW-1:0];

  // State word: {bin position, bin low, bin high}
  logic [WordW-1:0]        state_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] pos_vld_q;
  logic [WordW-1:0]        rd_word_q;
  logic                    rd_vld_q;

  logic                    mem_we;
  logic [IdxW-1:0]         wr_idx;
  logic [WordW-1:0]        wr_word;
  logic [PosW-1:0]         wr_pos;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      state_mem[wr_idx] <= wr_word;
    end
    if (in_fire) begin
      rd_word_q <= state_mem[rd_idx];
    end
  end

  // Valid bit per channel: an unwritten bin position reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q <= '0;
    end else if (mem_we) begin
      pos_vld_q[wr_idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers
  // ---------------------------------------------------------------------------
  logic                        s1_v_q;
  logic [ped_pkg::ChanW-1:0]   s1_ch_q;
  logic signed [SW-1:0]        s1_sample_q;
  logic                        s1_last_q;
  logic                        fwd_q;
  logic [WordW-1:0]            fwd_word_q;
  logic                        fwd_d;
  logic                        s1_go;

  // Forward the word being written when the next sample hits the same channel.
  assign fwd_d = mem_we && (s1_ch_q == in_i.data.channel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_go) begin
      s1_v_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q     <= in_i.data.channel;
      s1_sample_q <= in_i.data.sample;
      s1_last_q   <= in_i.data.block_end;
      rd_vld_q    <= pos_vld_q[rd_idx];
      fwd_q       <= fwd_d;
      fwd_word_q  <= wr_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: update the bin and decide on a point
  // ---------------------------------------------------------------------------
  logic [WordW-1:0]      cur_word;
  logic                  cur_vld;
  logic [PosW-1:0]       pos;
  logic signed [SW-1:0]  old_lo, old_hi, new_lo, new_hi;
  logic [PosW:0]         next_pos;
  logic                  in_range, shown, s1_act;
  logic                  close, is_neural, is_analog, emit;
  logic signed [SW:0]    lo_x, hi_x, abs_lo, abs_hi;
  ped_pkg::out_item_t    res;

  always_comb begin
    cur_word = fwd_q ? fwd_word_q : rd_word_q;
    cur_vld  = fwd_q || rd_vld_q;
    pos      = cur_vld ? cur_word[WordW-1 -: PosW] : '0;
    old_lo   = cur_word[2*SW-1 -: SW];
    old_hi   = cur_word[SW-1:0];

    in_range  = {1'b0, s1_ch_q} < LimW'(MAX_CHANNELS);
    shown     = shown_mask_q[s1_ch_q];
    s1_act    = s1_v_q && in_range && shown;
    is_neural = {1'b0, s1_ch_q} < neural_limit_q;
    is_analog = {1'b0, s1_ch_q} < analog_limit_q;

    next_pos = {1'b0, pos} + (PosW+1)'(1);
    close    = s1_last_q || (BsW'(next_pos) >= size_eff);

    // Neural bins track extrema; other classes keep them untouched.
    if (!is_neural) begin
      new_lo = old_lo;
      new_hi = old_hi;
    end else if (pos == '0) begin
      new_lo = s1_sample_q;
      new_hi = s1_sample_q;
    end else begin
      new_lo = (s1_sample_q < old_lo) ? s1_sample_q : old_lo;
      new_hi = (s1_sample_q > old_hi) ? s1_sample_q : old_hi;
    end

    lo_x   = {new_lo[SW-1], new_lo};
    hi_x   = {new_hi[SW-1], new_hi};
    abs_lo = new_lo[SW-1] ? -lo_x : lo_x;
    abs_hi = new_hi[SW-1] ? -hi_x : hi_x;

    res.out_channel = s1_ch_q;
    if (is_neural) begin
      emit     = s1_act && close;
      res.kind = ped_pkg::KIND_NEURAL;
      // Larger magnitude wins; a tie goes to the maximum.
      res.point = (abs_lo > abs_hi) ? new_lo : new_hi;
    end else begin
      emit      = s1_act && (pos == '0);
      res.kind  = is_analog ? ped_pkg::KIND_ANALOG : ped_pkg::KIND_DIGITAL;
      res.point = s1_sample_q;
    end

    wr_pos  = close ? '0 : next_pos[PosW-1:0];
    wr_word = {wr_pos, new_lo, new_hi};
    wr_idx  = s1_ch_q[IdxW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Output register and flow control
  // ---------------------------------------------------------------------------
  logic                out_v_q, out_v_d, out_load;
  ped_pkg::out_item_t  out_data_q;

  // Stage 1 advances unless it holds a point and the output slot stays full.
  assign s1_go    = !s1_v_q || !emit || !out_v_q || out_o.ready;
  assign in_ready = s1_go;
  assign mem_we   = s1_v_q && s1_go && s1_act;
  assign out_load = s1_v_q && s1_go && emit;
  assign out_v_d  = out_load || (out_v_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_on_blocked_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && emit && out_v_q && !out_o.ready) |-> !in_ready)
    else $error("sample accepted while a point is blocked");

  a_pos_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (BsW'(wr_pos) < size_eff))
    else $error("bin position written at or past bin size");

  a_out_from_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s1_v_q))
    else $error("output point without a sample in the compare stage");

  a_fwd_same_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && fwd_d) |=> (s1_v_q && fwd_q && ($past(s1_ch_q) == s1_ch_q)))
    else $error("forwarded word taken for a different channel");

endmodule

>>> tb/tb_peak_extremum_decimator.sv
// Self-checking testbench for the peak extremum decimator: drives interleaved samples,
// predicts every decimated point and compares the output stream field by field.
// Depends on hdl/ped_pkg.sv, hdl/ped_stream_if.sv and hdl/peak_extremum_decimator.sv.
module tb_peak_extremum_decimator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumChan     = 64;
  localparam int unsigned MaxBin      = 4096;
  // A point reaches the output register by way of stage 1; leave margin.
  localparam int unsigned DrainCycles = 6;
  // Receiver hold long enough to back the pipeline up into the input.
  localparam int unsigned LongHold    = 200;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned MaxReports  = 50;

  // How eagerly a side moves: never waits, waits a drawn gap before every item, or waits now and then.
  typedef enum int unsigned {
    PACE_EAGER,
    PACE_LAZY,
    PACE_MIXED
  } pace_e;

  // Predicts the decimated points and holds the ones not yet seen on the output.
  class point_book;
    logic [ped_pkg::BinSizeW-1:0]       bin_size;
    logic [ped_pkg::LimitW-1:0]         neural_limit;
    logic [ped_pkg::LimitW-1:0]         analog_limit;
    logic [ped_pkg::CfgW-1:0]           shown_mask;
    logic [11:0]                        bin_pos [NumChan];
    logic signed [ped_pkg::SampleW-1:0] bin_low [NumChan];
    logic signed [ped_pkg::SampleW-1:0] bin_high [NumChan];
    ped_pkg::out_item_t                 due [$];
    int unsigned                        errors;

    function new();
      bin_size     = 1;
      neural_limit = '0;
      analog_limit = '0;
      shown_mask   = '1;
      errors       = 0;
      for (int c = 0; c < NumChan; c++) begin
        bin_pos[c]  = '0;
        bin_low[c]  = '0;
        bin_high[c] = '0;
      end
    endfunction

    function void set_reg(ped_pkg::cfg_idx_e idx, logic [ped_pkg::CfgW-1:0] val);
      case (idx)
        ped_pkg::CFG_BIN_SIZE:     bin_size = val[ped_pkg::BinSizeW-1:0];
        ped_pkg::CFG_NEURAL_LIMIT: neural_limit = val[ped_pkg::LimitW-1:0];
        ped_pkg::CFG_ANALOG_LIMIT: analog_limit = val[ped_pkg::LimitW-1:0];
        ped_pkg::CFG_SHOWN_MASK:   shown_mask = val;
        default: ;
      endcase
    endfunction

    function void take_sample(ped_pkg::in_item_t it);
      int unsigned                        ch;
      int unsigned                        span;
      int unsigned                        pos;
      int                                 lo_v;
      int                                 hi_v;
      bit                                 closing;
      logic signed [ped_pkg::SampleW-1:0] s;
      ped_pkg::out_item_t                 pt;
      ch = it.channel;
      s  = it.sample;
      if (!shown_mask[ch]) return;
      span    = (bin_size == 0) ? 1 : (bin_size > MaxBin) ? MaxBin : bin_size;
      pos     = bin_pos[ch];
      closing = it.block_end || (pos + 1 >= span);
      pt.out_channel = it.channel;
      if (ch < neural_limit) begin
        if (pos == 0) begin
          bin_low[ch]  = s;
          bin_high[ch] = s;
        end else begin
          if (s < bin_low[ch]) bin_low[ch] = s;
          if (s > bin_high[ch]) bin_high[ch] = s;
        end
        if (closing) begin
          lo_v = bin_low[ch];
          hi_v = bin_high[ch];
          // larger magnitude wins, a tie goes to the maximum
          pt.point = ((lo_v < 0 ? -lo_v : lo_v) > (hi_v < 0 ? -hi_v : hi_v)) ?
                     bin_low[ch] : bin_high[ch];
          pt.kind  = ped_pkg::KIND_NEURAL;
          due.push_back(pt);
        end
      end else if (pos == 0) begin
        pt.point = s;
        pt.kind  = (ch < analog_limit) ? ped_pkg::KIND_ANALOG : ped_pkg::KIND_DIGITAL;
        due.push_back(pt);
      end
      bin_pos[ch] = closing ? 12'd0 : 12'(pos + 1);
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when the block is badly off
      if (errors <= MaxReports) $display("%0t ERROR %s", $time, msg);
    endtask

    task match_point(ped_pkg::out_item_t got);
      ped_pkg::out_item_t want;
      if (due.size() == 0) begin
        report($sformatf("point with nothing pending: ch %0d value %0d kind %0d",
                         got.out_channel, got.point, got.kind));
        return;
      end
      want = due.pop_front();
      if (got.out_channel !== want.out_channel)
        report($sformatf("out_channel %0d, want %0d", got.out_channel, want.out_channel));
      if (got.point !== want.point)
        report($sformatf("point %0d on ch %0d, want %0d", got.point, want.out_channel,
                         want.point));
      if (got.kind !== want.kind)
        report($sformatf("kind %0d on ch %0d, want %0d", got.kind, want.out_channel,
                         want.kind));
    endtask

    task check_drained();
      if (due.size() != 0) report($sformatf("%0d points never arrived", due.size()));
    endtask
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [ped_pkg::CfgIdxW-1:0] cfg_idx;
  logic [ped_pkg::CfgW-1:0]    cfg_wdata;

  ped_stream_if #(.T(ped_pkg::in_item_t))  sample_ch ();
  ped_stream_if #(.T(ped_pkg::out_item_t)) point_ch ();

  peak_extremum_decimator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (sample_ch),
    .out_o       (point_ch)
  );

  point_book   book;
  pace_e       src_pace  = PACE_EAGER;
  pace_e       sink_pace = PACE_EAGER;
  bit          hold_req  = 1'b0;
  int unsigned sent_shown = 0;
  int unsigned sent_total = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap(pace_e pace);
    case (pace)
      PACE_LAZY:  return $urandom_range(0, 17);
      PACE_MIXED: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      default:    return 0;
    endcase
  endfunction

  // Bias toward full-scale values and small clustered values so that magnitude ties
  // and the most negative code show up often.
  function automatic logic signed [ped_pkg::SampleW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return 16'sh8001;
          default: return 16'sh0000;
        endcase
      end
      1:       return ped_pkg::SampleW'(int'($urandom_range(0, 6)) - 3);
      default: return ped_pkg::SampleW'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until the block takes it. Valid stays high into the
  // next item when no gap is drawn.
  task automatic send_sample(input logic [ped_pkg::ChanW-1:0] ch,
                             input logic signed [ped_pkg::SampleW-1:0] s,
                             input logic be);
    int unsigned       gap;
    ped_pkg::in_item_t it;
    it.channel   = ch;
    it.sample    = s;
    it.block_end = be;
    gap = draw_gap(src_pace);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= it;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    if (book.shown_mask[ch]) sent_shown++;
    sent_total++;
    book.take_sample(it);
  endtask

  // Drop valid and wait until every predicted point has come out, then let the
  // pipeline finish any sample that emits nothing.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write enable is left high; the caller drops it after the last write of a group.
  task automatic write_reg(input ped_pkg::cfg_idx_e idx,
                           input logic [ped_pkg::CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    book.set_reg(idx, val);
  endtask

  // Load a full setting with the block idle. A channel that turns neural in the middle
  // of a bin would read extrema that were never written, so before the neural limit
  // moves, show every channel and close each open bin with a block end.
  task automatic apply_setting(input logic [ped_pkg::BinSizeW-1:0] bin,
                               input logic [ped_pkg::LimitW-1:0] nl,
                               input logic [ped_pkg::LimitW-1:0] al,
                               input logic [ped_pkg::CfgW-1:0] mask);
    settle();
    if (nl != book.neural_limit) begin
      write_reg(ped_pkg::CFG_SHOWN_MASK, '1);
      cfg_we <= 1'b0;
      for (int c = 0; c < NumChan; c++)
        if (book.bin_pos[c] != 0) send_sample(ped_pkg::ChanW'(c), rand_sample(), 1'b1);
      settle();
    end
    write_reg(ped_pkg::CFG_BIN_SIZE, ped_pkg::CfgW'(bin));
    write_reg(ped_pkg::CFG_NEURAL_LIMIT, ped_pkg::CfgW'(nl));
    write_reg(ped_pkg::CFG_ANALOG_LIMIT, ped_pkg::CfgW'(al));
    write_reg(ped_pkg::CFG_SHOWN_MASK, mask);
    cfg_we <= 1'b0;
  endtask

  // One setting, then mostly well-formed blocks: every channel of [lo, hi] per time
  // point, block end on the last time point. The rest are stray samples and blocks
  // with channels missing.
  task automatic run_phase(input logic [ped_pkg::BinSizeW-1:0] bin,
                           input logic [ped_pkg::LimitW-1:0] nl,
                           input logic [ped_pkg::LimitW-1:0] al,
                           input logic [ped_pkg::CfgW-1:0] mask,
                           input int unsigned lo, input int unsigned hi,
                           input int unsigned max_block, input int unsigned n_items,
                           input bit hold_mid = 1'b0, input bit drain_mid = 1'b0);
    int unsigned shown0;
    int unsigned total0;
    int unsigned blk;
    int unsigned ch;
    bit          broken;
    apply_setting(bin, nl, al, mask);
    src_pace  = hold_mid ? PACE_EAGER : pace_e'($urandom_range(0, 2));
    sink_pace = pace_e'($urandom_range(0, 2));
    shown0 = sent_shown;
    total0 = sent_total;
    while (sent_shown - shown0 < n_items && sent_total - total0 < 4 * n_items) begin
      if (sent_shown - shown0 >= n_items / 2) begin
        // stall the output while samples keep coming, so the input backs up
        if (hold_mid) hold_req = 1'b1;
        hold_mid = 1'b0;
        // pause the input once until the output has caught up
        if (drain_mid) settle();
        drain_mid = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) begin
        ch = $urandom_range(0, NumChan - 1);
        send_sample(ped_pkg::ChanW'(ch), rand_sample(), $urandom_range(0, 3) == 0);
      end else begin
        blk    = $urandom_range(1, max_block);
        broken = ($urandom_range(0, 5) == 0);
        for (int t = 0; t < blk; t++)
          for (int c = lo; c <= hi; c++) begin
            if (broken && $urandom_range(0, 3) == 0) continue;
            send_sample(ped_pkg::ChanW'(c), rand_sample(), t == blk - 1);
          end
      end
    end
  endtask

  // Receiver: wait a drawn number of cycles, then take one point and check it.
  initial begin
    int unsigned gap;
    point_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap      = hold_req ? LongHold : draw_gap(sink_pace);
      hold_req = 1'b0;
      if (gap != 0) begin
        point_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      point_ch.ready <= 1'b1;
      do @(posedge clk); while (point_ch.valid !== 1'b1);
      book.match_point(point_ch.data);
    end
  end

  // Count cycles in which neither side transfers anything.
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (point_ch.valid && point_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("peak_extremum_decimator: mismatch");
    $finish;
  end

  initial begin
    logic [ped_pkg::BinSizeW-1:0] bin;
    int unsigned                  lo;
    book = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= ped_pkg::CFG_BIN_SIZE;
    cfg_wdata       <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: bin of one, every channel digital and shown, so each sample
    // comes straight back.
    send_sample(0, 16'sh7FFF, 1'b0);
    send_sample(63, 16'sh8000, 1'b0);
    send_sample(21, -1, 1'b1);

    // Bin of three; channels 0-1 neural, 2-3 analog (3 hidden), 4 and up digital.
    apply_setting(3, 2, 4, ~(64'd1 << 3));
    send_sample(0, -5, 1'b0);          // equal magnitudes: the maximum wins
    send_sample(0, 5, 1'b0);
    send_sample(0, 2, 1'b0);
    send_sample(1, 16'sh8000, 1'b0);   // most negative beats the largest positive
    send_sample(1, 16'sh7FFF, 1'b0);
    send_sample(1, 0, 1'b0);
    send_sample(2, 7, 1'b1);           // analog pick on a one-sample block
    send_sample(3, 100, 1'b0);         // hidden: no point, no state change
    send_sample(4, 1, 1'b0);           // digital: first of the bin only
    send_sample(4, 2, 1'b0);
    send_sample(4, 3, 1'b0);
    send_sample(0, 9, 1'b1);           // block end flushes a one-sample neural bin
    send_sample(1, -1, 1'b0);
    send_sample(1, 1, 1'b1);           // short bin with a tie
    send_sample(3, 55, 1'b1);          // hidden channel keeps its position

    // Bin size zero acts as one: every neural sample is its own bin.
    apply_setting(0, 64, 64, '1);
    send_sample(10, -3, 1'b0);
    send_sample(63, 16'sh7FFF, 1'b0);

    // Everything hidden.
    apply_setting(0, 64, 64, '0);
    send_sample(7, 12, 1'b0);
    send_sample(40, -12, 1'b1);

    // Random part.
    run_phase(4, 4, 6, '1, 0, 7, 10, 100);
    run_phase(1, 3, 5, '1, 0, 63, 2, 100, 1'b1);
    run_phase(7, 127, 0, {$urandom, $urandom} | {$urandom, $urandom}, 32, 47, 12, 70);
    run_phase(3, 0, 64, '1, 0, 63, 4, 60);
    run_phase(5, 0, 0, {$urandom, $urandom}, 56, 63, 8, 50);
    run_phase(4096, 8, 100, '1, 0, 11, 4, 70);
    run_phase(12, 8, 12, '1, 0, 15, 20, 100, 1'b0, 1'b1);
    // Shrink the bin with positions still open: those bins close on the next sample.
    run_phase(3, 8, 12, '1, 0, 15, 6, 50);

    // Oversized bin saturates: a long run on one neural channel stays in one bin
    // until the block end flushes it.
    apply_setting(8191, 1, 1, 64'd1);
    src_pace = PACE_EAGER;
    for (int k = 0; k < 40; k++) send_sample(0, rand_sample(), 1'b0);
    send_sample(0, rand_sample(), 1'b1);

    for (int p = 0; p < 3; p++) begin
      bin = ($urandom_range(0, 3) == 0) ? ped_pkg::BinSizeW'($urandom_range(0, 8191)) :
                                          ped_pkg::BinSizeW'($urandom_range(1, 9));
      lo  = $urandom_range(0, NumChan - 1);
      run_phase(bin, ped_pkg::LimitW'($urandom_range(0, 70)),
                ped_pkg::LimitW'($urandom_range(0, 70)),
                {$urandom, $urandom} | {$urandom, $urandom}, lo,
                (lo + 15 > NumChan - 1) ? NumChan - 1 : lo + $urandom_range(0, 15),
                $urandom_range(1, 12), 50);
    end

    settle();
    book.check_drained();
    if (book.errors == 0)
      $display("peak_extremum_decimator: match");
    else
      $display("peak_extremum_decimator: mismatch");
    $finish;
  end
endmodule
